[rtl/core/rcc_pkg.sv]
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types and constants of the log record checker: transaction
// structures, field codes, register indexes and CRC-32 constants.
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 32;
   localparam int CSR_INDEX_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH       = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUT_OPCODE    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELETE_OPCODE = 8'd1;

   localparam logic [7:0] PUT_OPCODE_RESET    = 8'd1;
   localparam logic [7:0] DELETE_OPCODE_RESET = 8'd2;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic [2:0] STATUS_PROGRESS  = 3'd0;
   localparam logic [2:0] STATUS_GOOD      = 3'd1;
   localparam logic [2:0] STATUS_MISMATCH  = 3'd2;
   localparam logic [2:0] STATUS_BAD_HDR   = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;
   localparam logic [2:0] STATUS_CLEAN_END = 3'd5;

   typedef enum logic [3:0] {
      PHASE_CRC   = 4'b0001,
      PHASE_HDR   = 4'b0010,
      PHASE_KEY   = 4'b0100,
      PHASE_VALUE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [1:0]  payload_kind;
      logic        record_end;
      logic [2:0]  record_status;
      logic        is_delete;
      logic [31:0] key_length;
      logic [31:0] value_length;
   } rsp_type;

endpackage

[rtl/core/rcc_crc_byte.sv]
// ----------------------------------------------------------------------------
// rcc_crc_byte
// Reflected CRC-32 update over one byte, eight shift steps.
// ----------------------------------------------------------------------------
module rcc_crc_byte (
   input  logic [31:0] crc,
   input  logic [7:0]  data,
   output logic [31:0] crc_next
);
   import rcc_pkg::*;

   always_comb begin
      logic [31:0] acc;
      acc = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         acc = acc[0] ? (CRC_POLY ^ (acc >> 1)) : (acc >> 1);
      end
      crc_next = acc;
   end

endmodule

[rtl/core/rcc_parser.sv]
// ----------------------------------------------------------------------------
// rcc_parser
// Record state machine: collects the stored CRC and header, checks the
// running CRC and produces at most one result per accepted transaction.
// ----------------------------------------------------------------------------
module rcc_parser #(
   parameter int LENGTH_WIDTH = rcc_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  rcc_pkg::req_type in_item,
   input  logic [7:0]       put_opcode,
   input  logic [7:0]       delete_opcode,
   output logic             res_valid,
   output rcc_pkg::rsp_type res_item
);
   import rcc_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [31:0]             stored_ff, stored_in;
   logic [31:0]             crc_ff, crc_in, crc_next;
   logic                    op_ok_ff, op_ok_in;
   logic                    op_del_ff, op_del_in;
   logic [31:0]             key_len_ff, key_len_in;
   logic [31:0]             val_len_ff, val_len_in;
   logic                    halted_ff, halted_in;
   logic [7:0]              b;
   logic                    clear_rec;
   logic                    last;
   logic                    rec_end;
   logic                    crc_match;
   logic                    bad_hdr;

   rcc_crc_byte u_crc (
      .crc      (crc_ff),
      .data     (b),
      .crc_next (crc_next)
   );

   assign b         = in_item.data_byte;
   assign cnt_inc   = cnt_ff + LENGTH_WIDTH'(1);
   assign crc_match = ((crc_next ^ CRC_ALL) == stored_ff);

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      stored_in  = stored_ff;
      crc_in     = crc_ff;
      op_ok_in   = op_ok_ff;
      op_del_in  = op_del_ff;
      key_len_in = key_len_ff;
      val_len_in = val_len_ff;
      halted_in  = halted_ff;
      clear_rec  = 1'b0;
      last       = 1'b0;
      rec_end    = 1'b0;
      bad_hdr    = 1'b0;
      res_valid  = 1'b0;
      res_item.payload_byte  = 8'd0;
      res_item.payload_kind  = KIND_NONE;
      res_item.record_end    = 1'b0;
      res_item.record_status = STATUS_PROGRESS;
      res_item.is_delete     = 1'b0;
      res_item.key_length    = 32'd0;
      res_item.value_length  = 32'd0;

      if (in_accept) begin
         if (in_item.end_of_stream) begin
            res_valid = 1'b1;
            res_item.record_end = 1'b1;
            res_item.record_status =
               (halted_ff || (phase_ff == PHASE_CRC && cnt_ff == '0)) ?
               STATUS_CLEAN_END : STATUS_TRUNCATED;
            halted_in = 1'b0;
            clear_rec = 1'b1;
         end else if (!halted_ff) begin
            case (phase_ff)
               PHASE_CRC: begin
                  case (cnt_ff[1:0])
                     2'd0:    stored_in[7:0]   = b;
                     2'd1:    stored_in[15:8]  = b;
                     2'd2:    stored_in[23:16] = b;
                     default: stored_in[31:24] = b;
                  endcase
                  if (cnt_ff[1:0] == 2'd3) begin
                     phase_in = PHASE_HDR;
                     cnt_in   = '0;
                     crc_in   = CRC_ALL;
                  end else begin
                     cnt_in = cnt_inc;
                  end
               end
               PHASE_HDR: begin
                  crc_in = crc_next;
                  case (cnt_ff[3:0])
                     4'd0: begin
                        op_ok_in  = (b == put_opcode) || (b == delete_opcode);
                        op_del_in = (b == delete_opcode) && (b != put_opcode);
                     end
                     4'd1:    key_len_in[7:0]   = b;
                     4'd2:    key_len_in[15:8]  = b;
                     4'd3:    key_len_in[23:16] = b;
                     4'd4:    key_len_in[31:24] = b;
                     4'd5:    val_len_in[7:0]   = b;
                     4'd6:    val_len_in[15:8]  = b;
                     4'd7:    val_len_in[23:16] = b;
                     4'd8:    val_len_in[31:24] = b;
                     default: ;
                  endcase
                  if (cnt_ff[3:0] == 4'd8) begin
                     cnt_in  = '0;
                     bad_hdr = !op_ok_ff || (key_len_ff == 32'd0) ||
                               ((key_len_ff >> LENGTH_WIDTH) != 32'd0) ||
                               ((val_len_in >> LENGTH_WIDTH) != 32'd0);
                     if (bad_hdr) begin
                        res_valid = 1'b1;
                        res_item.record_end    = 1'b1;
                        res_item.record_status = STATUS_BAD_HDR;
                        res_item.is_delete     = op_del_ff;
                        res_item.key_length    = key_len_ff;
                        res_item.value_length  = val_len_in;
                        halted_in = 1'b1;
                     end else begin
                        phase_in = PHASE_KEY;
                     end
                  end else begin
                     cnt_in = cnt_inc;
                  end
               end
               PHASE_KEY, PHASE_VALUE: begin
                  crc_in = crc_next;
                  cnt_in = cnt_inc;
                  if (phase_ff == PHASE_KEY) begin
                     last = (32'(cnt_inc) >= key_len_ff);
                     if (last) begin
                        cnt_in = '0;
                        if (val_len_ff == 32'd0) begin
                           rec_end = 1'b1;
                        end else begin
                           phase_in = PHASE_VALUE;
                        end
                     end
                  end else begin
                     last    = (32'(cnt_inc) >= val_len_ff);
                     rec_end = last;
                  end
                  res_valid = 1'b1;
                  res_item.payload_byte = b;
                  res_item.payload_kind =
                     (phase_ff == PHASE_KEY) ? KIND_KEY : KIND_VALUE;
                  res_item.record_end   = rec_end;
                  res_item.is_delete    = op_del_ff;
                  res_item.key_length   = key_len_ff;
                  res_item.value_length = val_len_ff;
                  if (rec_end) begin
                     if (crc_match) begin
                        res_item.record_status = STATUS_GOOD;
                        clear_rec = 1'b1;
                     end else begin
                        res_item.record_status = STATUS_MISMATCH;
                        halted_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (clear_rec) begin
         phase_in   = PHASE_CRC;
         cnt_in     = '0;
         stored_in  = 32'd0;
         crc_in     = CRC_ALL;
         op_ok_in   = 1'b0;
         op_del_in  = 1'b0;
         key_len_in = 32'd0;
         val_len_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_CRC;
         cnt_ff     <= '0;
         stored_ff  <= 32'd0;
         crc_ff     <= CRC_ALL;
         op_ok_ff   <= 1'b0;
         op_del_ff  <= 1'b0;
         key_len_ff <= 32'd0;
         val_len_ff <= 32'd0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         stored_ff  <= stored_in;
         crc_ff     <= crc_in;
         op_ok_ff   <= op_ok_in;
         op_del_ff  <= op_del_in;
         key_len_ff <= key_len_in;
         val_len_ff <= val_len_in;
         halted_ff  <= halted_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (in_accept && !in_item.end_of_stream && halted_ff) |-> !res_valid)
      else $error("A data byte produced a result while the checker was halted.");

   assert property (@(posedge clock) disable iff (reset)
      (in_accept && in_item.end_of_stream) |=> (!halted_ff && phase_ff == PHASE_CRC))
      else $error("End of stream did not re-arm the checker.");

   assert property (@(posedge clock) disable iff (reset)
      (in_accept && !in_item.end_of_stream && phase_ff == PHASE_CRC) |-> !res_valid)
      else $error("A stored CRC byte produced a result.");

endmodule

[rtl/core/rcc_out_buffer.sv]
// ----------------------------------------------------------------------------
// rcc_out_buffer
// Result register with a skid stage, so that a new transaction can be taken
// while a finished result is still stalled at the output.
// ----------------------------------------------------------------------------
module rcc_out_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rcc_pkg::rsp_type in_item,
   output logic             in_stall,
   output logic             out_valid,
   output rcc_pkg::rsp_type out_item,
   input  logic             out_stall
);
   import rcc_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_item_ff, skid_item_in;
   logic    room;

   assign room = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (room) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_item_in   = skid_valid_ff ? skid_item_ff : in_item;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid stage holds a result while the output register is empty.");

endmodule

[rtl/core/log_record_checker_crc32.sv]
// ----------------------------------------------------------------------------
// log_record_checker_crc32
// Checks a length-prefixed log stream byte by byte against per-record CRC-32.
// ----------------------------------------------------------------------------
// One byte transaction is taken every clock cycle unless the request side
// stalls. The record state and the CRC-32 update are computed in a single
// pass at acceptance, and each result is held in a result register with a
// skid stage before it appears on the response channel; the request side
// stalls only when both of these hold results. Key and value bytes are
// forwarded as they arrive, the last byte of a record carries the good or
// mismatch status, and an end-of-stream transaction always returns one
// result and re-arms the checker after a bad header or a CRC mismatch.
// Opcode registers are written through the CSR port, which is always ready.
module log_record_checker_crc32 #(
   parameter int LENGTH_WIDTH = rcc_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rcc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rcc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rcc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import rcc_pkg::*;

   logic [7:0] put_opcode_ff, put_opcode_in;
   logic [7:0] delete_opcode_ff, delete_opcode_in;
   logic       req_accept;
   logic       res_valid;
   rsp_type    res_item;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      put_opcode_in    = put_opcode_ff;
      delete_opcode_in = delete_opcode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PUT_OPCODE:    put_opcode_in    = csr_wdata;
            CSR_DELETE_OPCODE: delete_opcode_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         put_opcode_ff    <= PUT_OPCODE_RESET;
         delete_opcode_ff <= DELETE_OPCODE_RESET;
      end else begin
         put_opcode_ff    <= put_opcode_in;
         delete_opcode_ff <= delete_opcode_in;
      end
   end

   rcc_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_accept     (req_accept),
      .in_item       (req_payload),
      .put_opcode    (put_opcode_ff),
      .delete_opcode (delete_opcode_ff),
      .res_valid     (res_valid),
      .res_item      (res_item)
   );

   rcc_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_item  (rsp_payload),
      .out_stall (rsp_stall)
   );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the log record checker. A queue of byte
// transactions is fed through a driver with random gaps. Well-formed records,
// CRC mismatches, rejected headers, truncations, oversized lengths and noise
// are all generated. Every accepted transaction is predicted by a behavioural
// copy of the checker, and a monitor with random stalls compares each result.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcc_pkg::*;

   localparam int LEN_W = LENGTH_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS = 325;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 8'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   log_record_checker_crc32 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   req_type log_feed[$];
   rsp_type due_results[$];
   rsp_type oldest_due;
   int      bytes_queued = 0;
   int      bytes_counted = 0;
   int      bytes_taken = 0;
   int      results_seen = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   logic [7:0]  opcode_put;
   logic [7:0]  opcode_delete;
   phase_type   pred_phase;
   logic [31:0] pred_count;
   logic [31:0] pred_stored_crc;
   logic [31:0] pred_crc;
   logic        pred_delete;
   logic        pred_op_ok;
   logic [31:0] pred_key_len;
   logic [31:0] pred_value_len;
   logic        pred_halted;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic int pick_idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_len(input int lo);
      return ($urandom_range(0, 9) == 0) ? $urandom_range(lo, 48) : $urandom_range(lo, 6);
   endfunction

   task automatic clear_record();
      pred_phase      = PHASE_CRC;
      pred_count      = '0;
      pred_stored_crc = '0;
      pred_crc        = CRC_ALL;
      pred_delete     = 1'b0;
      pred_op_ok      = 1'b0;
      pred_key_len    = '0;
      pred_value_len  = '0;
   endtask

   task automatic predict_log_transaction(input req_type item);
      rsp_type    res;
      logic [7:0] b;
      logic       closes;
      b = item.data_byte;
      res = '0;
      res.is_delete    = pred_delete;
      res.key_length   = pred_key_len;
      res.value_length = pred_value_len;
      if (item.end_of_stream) begin
         res = '0;
         res.payload_kind  = KIND_NONE;
         res.record_end    = 1'b1;
         res.record_status = (pred_halted || (pred_phase == PHASE_CRC && pred_count == 0)) ?
                             STATUS_CLEAN_END : STATUS_TRUNCATED;
         due_results.push_back(res);
         pred_halted = 1'b0;
         clear_record();
      end else if (!pred_halted) begin
         case (pred_phase)
            PHASE_CRC: begin
               pred_stored_crc[8*pred_count[1:0] +: 8] = b;
               pred_count++;
               if (pred_count == 4) begin
                  pred_phase = PHASE_HDR;
                  pred_count = '0;
                  pred_crc   = CRC_ALL;
               end
            end
            PHASE_HDR: begin
               pred_crc = crc32_byte(pred_crc, b);
               if (pred_count == 0) begin
                  pred_op_ok  = (b == opcode_put) || (b == opcode_delete);
                  pred_delete = (b == opcode_delete) && (b != opcode_put);
               end else if (pred_count <= 4) begin
                  pred_key_len[8*(pred_count-1) +: 8] = b;
               end else begin
                  pred_value_len[8*(pred_count-5) +: 8] = b;
               end
               pred_count++;
               if (pred_count == 9) begin
                  pred_count = '0;
                  if (!pred_op_ok || pred_key_len == 0 || (pred_key_len >> LEN_W) != 0 ||
                      (pred_value_len >> LEN_W) != 0) begin
                     res.payload_kind  = KIND_NONE;
                     res.record_end    = 1'b1;
                     res.record_status = STATUS_BAD_HDR;
                     res.is_delete     = pred_delete;
                     res.key_length    = pred_key_len;
                     res.value_length  = pred_value_len;
                     due_results.push_back(res);
                     pred_halted = 1'b1;
                  end else begin
                     pred_phase = PHASE_KEY;
                  end
               end
            end
            default: begin
               pred_crc = crc32_byte(pred_crc, b);
               pred_count++;
               res.payload_byte  = b;
               res.payload_kind  = (pred_phase == PHASE_KEY) ? KIND_KEY : KIND_VALUE;
               res.record_status = STATUS_PROGRESS;
               closes = 1'b0;
               if (pred_phase == PHASE_KEY) begin
                  if (pred_count >= pred_key_len) begin
                     pred_count = '0;
                     if (pred_value_len == 0) closes = 1'b1;
                     else pred_phase = PHASE_VALUE;
                  end
               end else if (pred_count >= pred_value_len) begin
                  closes = 1'b1;
               end
               if (closes) begin
                  res.record_end    = 1'b1;
                  res.record_status = ((pred_crc ^ CRC_ALL) == pred_stored_crc) ?
                                      STATUS_GOOD : STATUS_MISMATCH;
               end
               due_results.push_back(res);
               if (closes) begin
                  if (res.record_status == STATUS_MISMATCH) pred_halted = 1'b1;
                  else clear_record();
               end
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Driver: feeds queued byte transactions and predicts each one on acceptance.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         opcode_put    = PUT_OPCODE_RESET;
         opcode_delete = DELETE_OPCODE_RESET;
         pred_halted   = 1'b0;
         clear_record();
      end else begin
         if (req_valid && !req_stall) begin
            predict_log_transaction(req_payload);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (log_feed.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= log_feed.pop_front();
               gap_left = ((bytes_taken / 160) % 4 == 3) ? 0 : pick_idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks results and stalls at random, with occasional long hold-offs.
   int stall_left = 0;
   int hold_left = 0;
   int next_hold_at = 150;
   int span;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: %p", rsp_payload));
            end else begin
               oldest_due = due_results.pop_front();
               compare_field("payload_byte", 32'(rsp_payload.payload_byte),
                             32'(oldest_due.payload_byte));
               compare_field("payload_kind", 32'(rsp_payload.payload_kind),
                             32'(oldest_due.payload_kind));
               compare_field("record_end", 32'(rsp_payload.record_end),
                             32'(oldest_due.record_end));
               compare_field("record_status", 32'(rsp_payload.record_status),
                             32'(oldest_due.record_status));
               compare_field("is_delete", 32'(rsp_payload.is_delete),
                             32'(oldest_due.is_delete));
               compare_field("key_length", rsp_payload.key_length, oldest_due.key_length);
               compare_field("value_length", rsp_payload.value_length,
                             oldest_due.value_length);
            end
         end
         if (hold_left == 0 && bytes_taken >= next_hold_at) begin
            hold_left = 400;
            next_hold_at += 850;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            span = ((results_seen / 100) % 4 == 2) ? 0 : pick_idle_span();
            if (span == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               stall_left = span - 1;
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_item(input logic [7:0] data, input logic eos, input bit counts);
      req_type item;
      item.data_byte     = data;
      item.end_of_stream = eos;
      log_feed.push_back(item);
      bytes_queued++;
      if (counts) bytes_counted++;
   endtask

   task automatic queue_end();
      queue_item(8'($urandom), 1'b1, 1'b1);
   endtask

   task automatic queue_junk();
      repeat ($urandom_range(0, 4)) queue_item(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic queue_record(input logic [7:0] op, input logic [31:0] klen,
                               input logic [31:0] vlen, input logic [31:0] crc_flip,
                               input int keep);
      logic [7:0]  body[$];
      logic [31:0] crc;
      body.push_back(op);
      for (int i = 0; i < 4; i++) body.push_back(klen[8*i +: 8]);
      for (int i = 0; i < 4; i++) body.push_back(vlen[8*i +: 8]);
      while (body.size() + 4 < keep) body.push_back(8'($urandom));
      crc = CRC_ALL;
      foreach (body[i]) crc = crc32_byte(crc, body[i]);
      crc = crc ^ CRC_ALL ^ crc_flip;
      for (int i = 0; i < 4 && i < keep; i++) queue_item(crc[8*i +: 8], 1'b0, 1'b1);
      for (int i = 0; i + 4 < keep && i < body.size(); i++) queue_item(body[i], 1'b0, 1'b1);
   endtask

   task automatic queue_random_traffic(input int goal);
      int          r;
      int          sub;
      int          full;
      logic [7:0]  op;
      logic [31:0] klen;
      logic [31:0] vlen;
      while (bytes_counted < goal) begin
         r = $urandom_range(0, 99);
         op = $urandom_range(0, 1) ? opcode_put : opcode_delete;
         klen = pick_len(1);
         vlen = pick_len(0);
         full = 13 + int'(klen) + int'(vlen);
         if (r < 70) begin
            queue_record(op, klen, vlen, '0, full);
         end else if (r < 78) begin
            queue_record(op, klen, vlen, 32'd1 << $urandom_range(0, 31), full);
            queue_junk();
            queue_end();
         end else if (r < 85) begin
            sub = $urandom_range(0, 2);
            if (sub != 1) begin
               do op = 8'($urandom); while (op == opcode_put || op == opcode_delete);
            end
            if (sub != 0) begin
               klen = '0;
               vlen = $urandom;
            end
            queue_record(op, klen, vlen, '0, 13);
            queue_junk();
            queue_end();
         end else if (r < 91) begin
            queue_record(op, klen, vlen, '0, $urandom_range(1, full - 1));
            queue_end();
         end else if (r < 95) begin
            sub = $urandom_range(0, 3);
            if (sub == 0) begin
               klen = 32'hFFFF_FFFF;
               vlen = 32'hFFFF_FFFF;
            end else if (sub == 1) begin
               vlen = $urandom | (32'd1 << $urandom_range(8, 31));
            end else begin
               klen = $urandom | (32'd1 << $urandom_range(8, 31));
               vlen = $urandom;
            end
            queue_record(op, klen, vlen, '0, 13 + $urandom_range(0, 6) +
                         ((sub == 1) ? int'(klen) : 0));
            queue_end();
         end else if (r < 98) begin
            repeat ($urandom_range(1, 20)) queue_item(8'($urandom), 1'b0, 1'b1);
            queue_end();
         end else begin
            queue_end();
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_PUT_OPCODE) opcode_put = data;
      else if (index == CSR_DELETE_OPCODE) opcode_delete = data;
   endtask

   task automatic set_opcodes(input logic [7:0] put_op, input logic [7:0] delete_op);
      write_csr(CSR_PUT_OPCODE, put_op);
      write_csr(CSR_DELETE_OPCODE, delete_op);
   endtask

   task automatic wait_for_idle();
      while (bytes_taken != bytes_queued || due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] shared_op;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Clean end before any byte, a delete record failing its CRC, an
      // ignored byte while stopped, then a stream cut inside the stored CRC.
      queue_end();
      queue_record(DELETE_OPCODE_RESET, 32'd1, 32'd0, 32'd1, 14);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_end();
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b0, 1'b1);
      queue_end();

      for (int step = 0; step < 6; step++) begin
         case (step)
            1: set_opcodes(8'h00, 8'hFF);
            2: set_opcodes(8'hFF, 8'h00);
            3: begin
               shared_op = 8'($urandom);
               set_opcodes(shared_op, shared_op);
               write_csr(CSR_SPARE_INDEX, 8'($urandom));
            end
            4: set_opcodes(8'($urandom), 8'($urandom));
            5: set_opcodes(PUT_OPCODE_RESET, DELETE_OPCODE_RESET);
            default: ;
         endcase
         queue_random_traffic(bytes_counted + PHASE_ITEMS);
         wait_for_idle();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
